// File: rtl/core/ksic_pkg.sv
// ----------------------------------------------------------------------------
// ksic_pkg
// shared widths, register indexes and the sequencer microcode table
// ----------------------------------------------------------------------------
package ksic_pkg;

	// field widths
	localparam int KEY_W      = 64;
	localparam int SLOT_W     = 7;
	localparam int SYM_W      = 8;
	localparam int POS_W      = 4;
	localparam int ASIZE_W    = 8;
	localparam int MLEN_W     = 5;
	localparam int IN_DATA_W  = 80;
	localparam int OUT_DATA_W = 16;

	// parameter defaults
	localparam int DEF_MAX_SYMBOLS = 128;
	localparam int DEF_MAX_LEN     = 16;

	// register reset values
	localparam logic [ASIZE_W-1:0] ASIZE_RESET = 8'd26;
	localparam logic [MLEN_W-1:0]  MLEN_RESET  = 5'd8;

	// configuration port
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHABET_SIZE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH    = 1'd1;

	// divider: quotient bits retired per cycle
	localparam int DIV_BITS  = 8;
	localparam int DIV_ITERS = KEY_W / DIV_BITS;

	// datapath operations
	localparam int OP_W = 3;
	localparam logic [OP_W-1:0] OP_NOP       = 3'd0;
	localparam logic [OP_W-1:0] OP_ACCEPT    = 3'd1;
	localparam logic [OP_W-1:0] OP_SEARCH    = 3'd2;
	localparam logic [OP_W-1:0] OP_EMIT_OOR  = 3'd3;
	localparam logic [OP_W-1:0] OP_DIV_INIT  = 3'd4;
	localparam logic [OP_W-1:0] OP_DIV_STEP  = 3'd5;
	localparam logic [OP_W-1:0] OP_TBL_READ  = 3'd6;
	localparam logic [OP_W-1:0] OP_EMIT_CHAR = 3'd7;

	// jump conditions
	localparam int COND_W = 3;
	localparam logic [COND_W-1:0] C_ALWAYS      = 3'd0;
	localparam logic [COND_W-1:0] C_GEN         = 3'd1;
	localparam logic [COND_W-1:0] C_FOUND       = 3'd2;
	localparam logic [COND_W-1:0] C_MORE_LEN    = 3'd3;
	localparam logic [COND_W-1:0] C_OUT_FREE    = 3'd4;
	localparam logic [COND_W-1:0] C_DIV_DONE    = 3'd5;
	localparam logic [COND_W-1:0] C_DIGITS_LEFT = 3'd6;
	localparam logic [COND_W-1:0] C_CHARS_LEFT  = 3'd7;

	// action when the condition is false
	localparam int ELS_W = 2;
	localparam logic [ELS_W-1:0] E_HOLD = 2'd0;
	localparam logic [ELS_W-1:0] E_NEXT = 2'd1;
	localparam logic [ELS_W-1:0] E_HOME = 2'd2;

	// program steps
	localparam int STEP_W = 4;
	localparam logic [STEP_W-1:0] STEP_IDLE  = 4'd0;
	localparam logic [STEP_W-1:0] STEP_TEST  = 4'd1;
	localparam logic [STEP_W-1:0] STEP_GROW  = 4'd2;
	localparam logic [STEP_W-1:0] STEP_OOR   = 4'd3;
	localparam logic [STEP_W-1:0] STEP_DIVI  = 4'd4;
	localparam logic [STEP_W-1:0] STEP_DIV   = 4'd5;
	localparam logic [STEP_W-1:0] STEP_DNEXT = 4'd6;
	localparam logic [STEP_W-1:0] STEP_RD    = 4'd7;
	localparam logic [STEP_W-1:0] STEP_EMIT  = 4'd8;
	localparam logic [STEP_W-1:0] STEP_CHK   = 4'd9;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [COND_W-1:0] cond;
		logic [STEP_W-1:0] target;
		logic [ELS_W-1:0]  els;
	} ucode_t;

	function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
		ucode_t w;
		case (step)
			STEP_IDLE:  w = '{OP_ACCEPT,    C_GEN,         STEP_TEST,  E_HOLD};
			STEP_TEST:  w = '{OP_NOP,       C_FOUND,       STEP_DIVI,  E_NEXT};
			STEP_GROW:  w = '{OP_SEARCH,    C_MORE_LEN,    STEP_TEST,  E_NEXT};
			STEP_OOR:   w = '{OP_EMIT_OOR,  C_OUT_FREE,    STEP_IDLE,  E_HOLD};
			STEP_DIVI:  w = '{OP_DIV_INIT,  C_ALWAYS,      STEP_DIV,   E_NEXT};
			STEP_DIV:   w = '{OP_DIV_STEP,  C_DIV_DONE,    STEP_DNEXT, E_HOLD};
			STEP_DNEXT: w = '{OP_NOP,       C_DIGITS_LEFT, STEP_DIV,   E_NEXT};
			STEP_RD:    w = '{OP_TBL_READ,  C_ALWAYS,      STEP_EMIT,  E_NEXT};
			STEP_EMIT:  w = '{OP_EMIT_CHAR, C_OUT_FREE,    STEP_CHK,   E_HOLD};
			STEP_CHK:   w = '{OP_NOP,       C_CHARS_LEFT,  STEP_RD,    E_HOME};
			default:    w = '{OP_NOP,       C_ALWAYS,      STEP_IDLE,  E_HOME};
		endcase
		return w;
	endfunction

endpackage

// File: rtl/core/keyspace_index_to_candidate.sv
// ----------------------------------------------------------------------------
// keyspace_index_to_candidate
// maps a keyspace index to a candidate string over a loaded alphabet
// ----------------------------------------------------------------------------
// A word with tuser low loads one alphabet entry, gives no result and leaves
// tready high. A word with tuser high is a key index: the block finds the
// candidate length L, splits the remaining offset into L base-N digits and
// sends L result words, first character first, tlast on the final one; an
// index past the keyspace of max_length gives one word with tuser high. A
// generate word holds off the next word until it is done: the search runs a
// test and a grow step per length, each digit runs the divider steps (the
// shared 64-bit divider retires eight quotient bits a cycle) and a check, and
// each character runs a symbol table read, an output load and a loop check.
// Results sit in an output register, so tready on the input side comes back
// while the last word still waits. Control runs from a ten-step microcode
// table in the package.
// Alphabet entries must be loaded before a candidate uses them.

module keyspace_index_to_candidate
	import ksic_pkg::*;
#(
	parameter int MAX_SYMBOLS = DEF_MAX_SYMBOLS,
	parameter int MAX_LEN     = DEF_MAX_LEN
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// input stream
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// symbol_slot[6:0], symbol_value[14:7], key_index[78:15], zero[79]
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// opcode: 0 load, 1 generate
	input  logic                  s_axis_tuser,
	// result stream
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// out_char[7:0], char_position[11:8], zero[15:12]
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	// last_char
	output logic                  m_axis_tlast,
	// out_of_range
	output logic                  m_axis_tuser,
	// configuration writes
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DAT_W-1:0]  cfg_wr_data
);

	localparam int DW    = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
	localparam int LEN_W = $clog2(MAX_LEN + 2);
	localparam int CNT_W = $clog2(DIV_ITERS);
	localparam int PROD_W = KEY_W + ASIZE_W;

	// configuration
	logic [ASIZE_W-1:0] asize_q;
	logic [MLEN_W-1:0]  mlen_q;

	// sequencer
	logic [STEP_W-1:0] pc_q;
	logic [STEP_W-1:0] pc_nxt;
	ucode_t            uw;
	logic              cond_true;

	// datapath
	logic [KEY_W-1:0]  rem_q;       // offset in search, dividend in digit loop
	logic [KEY_W-1:0]  group_q;     // size of the current length group
	logic              big_q;       // group size saturated past 64 bits
	logic [LEN_W-1:0]  len_q;
	logic [LEN_W-1:0]  dk_q;        // digits still to extract
	logic [LEN_W-1:0]  pos_q;       // next character position to send
	logic [ASIZE_W-1:0] r_q;        // partial remainder of the divider
	logic [CNT_W-1:0]  div_cnt_q;
	logic [DW-1:0]     stack_q [MAX_LEN];   // digits, top at entry 0
	logic [SYM_W-1:0]  rd_q;
	logic [SYM_W-1:0]  tbl [MAX_SYMBOLS];

	// output register
	logic              out_valid_q;
	logic [SYM_W-1:0]  out_char_q;
	logic [POS_W-1:0]  out_pos_q;
	logic              out_last_q;
	logic              out_oor_q;

	logic               in_acc;
	logic               out_free;
	logic               load_out;
	logic               load_we;
	logic [SLOT_W-1:0]  in_slot;
	logic [SYM_W-1:0]   in_value;
	logic [KEY_W-1:0]   in_key;
	logic [ASIZE_W-1:0] n_eff;
	logic [LEN_W-1:0]   m_eff;
	logic [PROD_W-1:0]  prod;
	logic [ASIZE_W-1:0] r_nxt;
	logic [KEY_W-1:0]   q_nxt;
	logic               div_done;

	assign in_slot  = s_axis_tdata[SLOT_W-1:0];
	assign in_value = s_axis_tdata[SLOT_W+SYM_W-1:SLOT_W];
	assign in_key   = s_axis_tdata[SLOT_W+SYM_W+KEY_W-1:SLOT_W+SYM_W];

	assign uw            = ucode_rom(pc_q);
	assign s_axis_tready = (uw.op == OP_ACCEPT);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign load_we       = in_acc && !s_axis_tuser && (32'(in_slot) < MAX_SYMBOLS);

	assign out_free = !out_valid_q || m_axis_tready;
	assign load_out = out_free && ((uw.op == OP_EMIT_OOR) || (uw.op == OP_EMIT_CHAR));

	// effective alphabet size and maximum length, clamped to the build limits
	always_comb begin
		if (asize_q == '0) begin
			n_eff = ASIZE_W'(1);
		end else if (32'(asize_q) > MAX_SYMBOLS) begin
			n_eff = ASIZE_W'(MAX_SYMBOLS);
		end else begin
			n_eff = asize_q;
		end
		if (mlen_q == '0) begin
			m_eff = LEN_W'(1);
		end else if (32'(mlen_q) > MAX_LEN) begin
			m_eff = LEN_W'(MAX_LEN);
		end else begin
			m_eff = LEN_W'(mlen_q);
		end
	end

	// next group size; any bit above 64 means saturation
	assign prod = PROD_W'(group_q) * PROD_W'(n_eff);

	// restoring divider, DIV_BITS quotient bits a cycle, msb first
	always_comb begin
		logic [ASIZE_W:0] t;
		r_nxt = r_q;
		q_nxt = rem_q;
		for (int i = 0; i < DIV_BITS; i++) begin
			t     = {r_nxt, q_nxt[KEY_W-1]};
			q_nxt = {q_nxt[KEY_W-2:0], 1'b0};
			if (t >= {1'b0, n_eff}) begin
				r_nxt    = ASIZE_W'(t - {1'b0, n_eff});
				q_nxt[0] = 1'b1;
			end else begin
				r_nxt = t[ASIZE_W-1:0];
			end
		end
	end

	assign div_done = (div_cnt_q == CNT_W'(DIV_ITERS - 1));

	// jump conditions and step counter
	always_comb begin
		case (uw.cond)
			C_ALWAYS:      cond_true = 1'b1;
			C_GEN:         cond_true = in_acc && s_axis_tuser;
			C_FOUND:       cond_true = big_q || (rem_q < group_q);
			C_MORE_LEN:    cond_true = (len_q < m_eff);
			C_OUT_FREE:    cond_true = out_free;
			C_DIV_DONE:    cond_true = div_done;
			C_DIGITS_LEFT: cond_true = (dk_q != '0);
			C_CHARS_LEFT:  cond_true = (pos_q != len_q);
			default:       cond_true = 1'b0;
		endcase
		if (cond_true) begin
			pc_nxt = uw.target;
		end else begin
			case (uw.els)
				E_HOLD:  pc_nxt = pc_q;
				E_NEXT:  pc_nxt = pc_q + STEP_W'(1);
				E_HOME:  pc_nxt = STEP_IDLE;
				default: pc_nxt = STEP_IDLE;
			endcase
		end
	end

	// control state: config, step counter, loop counters, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			asize_q     <= ASIZE_RESET;
			mlen_q      <= MLEN_RESET;
			pc_q        <= STEP_IDLE;
			big_q       <= 1'b0;
			len_q       <= '0;
			dk_q        <= '0;
			pos_q       <= '0;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				if (cfg_index == REG_ALPHABET_SIZE) begin
					asize_q <= cfg_wr_data[ASIZE_W-1:0];
				end else if (cfg_index == REG_MAX_LENGTH) begin
					mlen_q <= cfg_wr_data[MLEN_W-1:0];
				end
			end
			pc_q <= pc_nxt;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (uw.op)
				OP_ACCEPT: begin
					if (in_acc && s_axis_tuser) begin
						big_q <= 1'b0;
						len_q <= LEN_W'(1);
					end
				end
				OP_SEARCH: begin
					len_q <= len_q + LEN_W'(1);
					if (|prod[PROD_W-1:KEY_W]) begin
						big_q <= 1'b1;
					end
				end
				OP_DIV_INIT: begin
					div_cnt_q <= '0;
					dk_q      <= len_q;
					pos_q     <= '0;
				end
				OP_DIV_STEP: begin
					if (div_done) begin
						div_cnt_q <= '0;
						dk_q      <= dk_q - LEN_W'(1);
					end else begin
						div_cnt_q <= div_cnt_q + CNT_W'(1);
					end
				end
				OP_EMIT_CHAR: begin
					if (out_free) begin
						pos_q <= pos_q + LEN_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// payload: offsets, divider, digit stack, output fields
	always_ff @(posedge clk) begin
		case (uw.op)
			OP_ACCEPT: begin
				if (in_acc && s_axis_tuser) begin
					rem_q   <= in_key;
					group_q <= KEY_W'(n_eff);
				end
			end
			OP_SEARCH: begin
				rem_q <= rem_q - group_q;
				if (!(|prod[PROD_W-1:KEY_W])) begin
					group_q <= prod[KEY_W-1:0];
				end
			end
			OP_EMIT_OOR: begin
				if (out_free) begin
					out_char_q <= '0;
					out_pos_q  <= '0;
					out_last_q <= 1'b1;
					out_oor_q  <= 1'b1;
				end
			end
			OP_DIV_INIT: begin
				r_q <= '0;
			end
			OP_DIV_STEP: begin
				rem_q <= q_nxt;
				if (div_done) begin
					// least significant digit first, so the first character ends on top
					r_q        <= '0;
					stack_q[0] <= DW'(r_nxt);
					for (int i = 1; i < MAX_LEN; i++) begin
						stack_q[i] <= stack_q[i-1];
					end
				end else begin
					r_q <= r_nxt;
				end
			end
			OP_TBL_READ: begin
				for (int i = 0; i < MAX_LEN - 1; i++) begin
					stack_q[i] <= stack_q[i+1];
				end
			end
			OP_EMIT_CHAR: begin
				if (out_free) begin
					out_char_q <= rd_q;
					out_pos_q  <= POS_W'(pos_q);
					out_last_q <= ((pos_q + LEN_W'(1)) == len_q);
					out_oor_q  <= 1'b0;
				end
			end
			default: ;
		endcase
	end

	// symbol table: one write port for loads, registered read at the stack top
	always_ff @(posedge clk) begin
		if (load_we) begin
			tbl[DW'(in_slot)] <= in_value;
		end
		if (uw.op == OP_TBL_READ) begin
			rd_q <= tbl[stack_q[0]];
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_DATA_W - SYM_W - POS_W){1'b0}}, out_pos_q, out_char_q};
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = out_oor_q;

endmodule

// File: rtl/core/ksic_checker.sv
// ----------------------------------------------------------------------------
// ksic_checker
// port-level checks for the keyspace index to candidate block
// ----------------------------------------------------------------------------
module ksic_checker
	import ksic_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_axis_tvalid,
	input logic                  s_axis_tready,
	input logic                  s_axis_tuser,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [OUT_DATA_W-1:0] m_axis_tdata,
	input logic                  m_axis_tlast,
	input logic                  m_axis_tuser
);

	// stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
			&& $stable(m_axis_tuser))
		else $error("result word changed while stalled");

	// out-of-range word is a single, empty, final word
	a_oor_form: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == '0))
		else $error("malformed out-of-range word");

	// a generate word occupies the sequencer
	a_gen_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser |=> !s_axis_tready)
		else $error("ready after a generate word");

	// a load word leaves the input ready on the next cycle
	a_load_fast: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && !s_axis_tuser |=> s_axis_tready)
		else $error("ready dropped after a load word");

	// no result during reset
	a_rst_quiet: assert property (@(posedge clk) !arst_n |-> !m_axis_tvalid)
		else $error("result valid in reset");

endmodule

bind keyspace_index_to_candidate ksic_checker u_ksic_checker (.*);

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for keyspace_index_to_candidate
// ----------------------------------------------------------------------------
// Fills the whole symbol table first, then walks a short table of directed
// words and then random phases under several keyspace settings. Every
// accepted generate word books its expected words, from a local model of the
// block or a typed directed row, and each result word is compared with the
// oldest expectation. Streams idle at random; the result side holds off for
// a long stretch once; the input side drains before each phase and mid-phase.
// ----------------------------------------------------------------------------

module tb_top;
	import ksic_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000; // quiet cycles before giving up
	localparam int SETTLE_CYCLES  = 40;   // wait after the last owed word; a load gives no result
	localparam int LONG_HOLD      = 300;  // result side back-pressure stretch
	localparam int PHASES         = 10;
	localparam int PHASE_WORDS    = 26;
	localparam int N_DIRECTED     = 17;
	localparam int REPORT_CAP     = 200;

	typedef enum logic {
		OPC_LOAD = 1'b0,
		OPC_GEN  = 1'b1
	} opcode_t;

	// one result word
	typedef struct packed {
		logic [SYM_W-1:0] out_char;
		logic [POS_W-1:0] char_position;
		logic             last_char;
		logic             out_of_range;
	} cand_char_t;

	// one row of the directed table; typed rows carry their single result
	typedef struct packed {
		opcode_t           op;
		logic [SLOT_W-1:0] slot;
		logic [SYM_W-1:0]  value;
		logic [KEY_W-1:0]  key;
		logic              typed;
		cand_char_t        want;
	} stim_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic                  s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tlast;
	logic                  m_axis_tuser;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DAT_W-1:0]  cfg_wr_data;

	// local copy of the block's state
	logic [SYM_W-1:0]   symbol_copy [DEF_MAX_SYMBOLS];
	logic [ASIZE_W-1:0] alphabet_cfg;
	logic [MLEN_W-1:0]  length_cfg;

	cand_char_t candidate_q [$];  // character words still owed by the block
	int unsigned fail_count;
	int unsigned quiet_cycles;
	bit source_idles;
	bit sink_idles;
	bit hold_outputs;               // asks the result side for a long hold-off

	// directed words; the table is preloaded with random bytes before these
	stim_row_t directed_rows [N_DIRECTED] = '{
		// boundary bytes into the slots used below
		'{OPC_LOAD, 7'd0,   8'h61, 64'd0,                  1'b0, '0},
		'{OPC_LOAD, 7'd127, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0},
		'{OPC_LOAD, 7'd1,   8'h00, 64'd0,                  1'b0, '0},
		'{OPC_LOAD, 7'd25,  8'h7A, 64'd0,                  1'b0, '0},
		// reset keyspace: 26 symbols, up to 8 characters
		'{OPC_GEN,  7'd0,   8'h00, 64'd0,                  1'b1, '{8'h61, 4'd0, 1'b1, 1'b0}},
		'{OPC_GEN,  7'd0,   8'h00, 64'd25,                 1'b1, '{8'h7A, 4'd0, 1'b1, 1'b0}},
		'{OPC_GEN,  7'd0,   8'h00, 64'd26,                 1'b0, '0},
		'{OPC_GEN,  7'd0,   8'h00, 64'd27,                 1'b0, '0},
		'{OPC_GEN,  7'd0,   8'h00, 64'd701,                1'b0, '0},
		'{OPC_GEN,  7'd0,   8'h00, 64'd702,                1'b0, '0},
		// last index of the keyspace, then the first one past it
		'{OPC_GEN,  7'd0,   8'h00, 64'd217180147157,       1'b0, '0},
		'{OPC_GEN,  7'd0,   8'h00, 64'd217180147158,       1'b1, '{8'h00, 4'd0, 1'b1, 1'b1}},
		'{OPC_GEN,  7'd127, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{8'h00, 4'd0, 1'b1, 1'b1}},
		'{OPC_GEN,  7'd85,  8'h55, 64'h5555_5555_5555_5555, 1'b1, '{8'h00, 4'd0, 1'b1, 1'b1}},
		'{OPC_LOAD, 7'd0,   8'h00, 64'h0123_4567_89AB_CDEF, 1'b0, '0},
		'{OPC_GEN,  7'd0,   8'h00, 64'd0,                  1'b1, '{8'h00, 4'd0, 1'b1, 1'b0}},
		'{OPC_GEN,  7'd0,   8'h00, 64'd12345,              1'b0, '0}
	};

	keyspace_index_to_candidate uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_wr_data   (cfg_wr_data)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// symbols in use, as the block clamps them
	function automatic int unsigned eff_alphabet();
		if (alphabet_cfg == 0) return 1;
		if (alphabet_cfg > DEF_MAX_SYMBOLS) return DEF_MAX_SYMBOLS;
		return 32'(alphabet_cfg);
	endfunction

	// longest candidate, as the block clamps it
	function automatic int unsigned eff_length();
		if (length_cfg == 0) return 1;
		if (length_cfg > DEF_MAX_LEN) return DEF_MAX_LEN;
		return 32'(length_cfg);
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	// books one owed result word at the tail of the queue
	function automatic void owe_word(input cand_char_t w);
		candidate_q = {candidate_q, w};
	endfunction

	// expands one key index into the character words it should produce;
	// group sizes are exact in 128 bits, so a group too big for 64 bits
	// always holds the remaining offset
	function automatic void predict_candidate(input logic [KEY_W-1:0] key);
		int unsigned n, m, len;
		logic [127:0] grp;
		logic [KEY_W-1:0] rem;
		logic [KEY_W-1:0] digit;
		logic [SYM_W-1:0] chars [DEF_MAX_LEN];
		cand_char_t r;
		n = eff_alphabet();
		m = eff_length();
		rem = key;
		len = 1;
		grp = 128'(n);
		// walk the length groups until the offset lands in one
		while ({64'd0, rem} >= grp) begin
			rem -= grp[KEY_W-1:0];
			len++;
			if (len > m) begin
				r = '{out_char: '0, char_position: '0, last_char: 1'b1, out_of_range: 1'b1};
				owe_word(r);
				return;
			end
			grp = grp * 128'(n);
		end
		// base-n digits, least significant into the last character
		for (int k = len - 1; k >= 0; k--) begin
			digit = rem % 64'(n);
			chars[k] = symbol_copy[digit[SLOT_W-1:0]];
			rem = rem / 64'(n);
		end
		for (int k = 0; k < len; k++) begin
			r.out_char      = chars[k];
			r.char_position = k[POS_W-1:0];
			r.last_char     = (k == len - 1);
			r.out_of_range  = 1'b0;
			owe_word(r);
		end
	endfunction

	// key index for a generate word: mostly inside a chosen length group,
	// some at group and keyspace edges, some anywhere in 64 bits
	function automatic logic [KEY_W-1:0] pick_key();
		int unsigned n, m, len, sel;
		logic [127:0] grp, total, lbase, lgrp, pick;
		n = eff_alphabet();
		m = eff_length();
		// favor short candidates, they cost far fewer cycles
		if ($urandom_range(99) < 70) len = $urandom_range((m < 4) ? m : 4, 1);
		else len = $urandom_range(m, 1);
		grp = 128'(n);
		total = '0;
		lbase = '0;
		lgrp = 128'(n);
		for (int i = 1; i <= m; i++) begin
			if (i == len) begin
				lbase = total;
				lgrp = grp;
			end
			total += grp;
			grp = grp * 128'(n);
		end
		sel = $urandom_range(99);
		if (sel < 60) pick = lbase + ({$urandom, $urandom, $urandom, $urandom} % lgrp);
		else if (sel < 70) pick = sel[0] ? lbase : lbase + lgrp - 128'd1;
		else if (sel < 80) pick = sel[0] ? total : total - 128'd1;
		else pick = {64'd0, $urandom, $urandom};
		if (pick[127:64] != 0) pick = {64'd0, $urandom, $urandom};
		return pick[KEY_W-1:0];
	endfunction

	// offers one word, waits for the handshake, then books what it owes
	task automatic send_word(input opcode_t op, input logic [SLOT_W-1:0] slot,
			input logic [SYM_W-1:0] value, input logic [KEY_W-1:0] key,
			input logic typed, input cand_char_t want);
		int unsigned gap;
		gap = source_idles ? idle_len() : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {1'b0, key, value, slot};
		do @(posedge clk); while (!s_axis_tready);
		if (op == OPC_LOAD) symbol_copy[slot] = value;
		else if (typed) owe_word(want);
		else predict_candidate(key);
	endtask

	// random word: a few table loads, the rest generates
	task automatic send_random_word();
		if ($urandom_range(99) < 15)
			send_word(OPC_LOAD, SLOT_W'($urandom_range(DEF_MAX_SYMBOLS - 1)),
				SYM_W'($urandom_range(255)), {$urandom, $urandom}, 1'b0, '0);
		else
			send_word(OPC_GEN, SLOT_W'($urandom_range(DEF_MAX_SYMBOLS - 1)),
				SYM_W'($urandom_range(255)), pick_key(), 1'b0, '0);
	endtask

	// stop offering and wait until every owed word is back and the block is idle
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (candidate_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// writes both registers on back-to-back cycles
	task automatic set_keyspace(input int unsigned asize, input int unsigned mlen);
		cfg_wr_en   <= 1'b1;
		cfg_index   <= REG_ALPHABET_SIZE;
		cfg_wr_data <= asize[CFG_DAT_W-1:0];
		@(posedge clk);
		cfg_index   <= REG_MAX_LENGTH;
		cfg_wr_data <= mlen[CFG_DAT_W-1:0];
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		alphabet_cfg = asize[ASIZE_W-1:0];
		length_cfg   = mlen[MLEN_W-1:0];
	endtask

	task automatic flag_field(input string field, input int unsigned want,
			input int unsigned got);
		if (fail_count < REPORT_CAP)
			$error("%s: expected 0x%0h, got 0x%0h", field, want, got);
		fail_count++;
	endtask

	// compares one accepted result word with the oldest expectation
	task automatic check_char_word();
		cand_char_t want, got;
		got.out_char      = m_axis_tdata[SYM_W-1:0];
		got.char_position = m_axis_tdata[SYM_W+POS_W-1:SYM_W];
		got.last_char     = m_axis_tlast;
		got.out_of_range  = m_axis_tuser;
		if (candidate_q.size() == 0) begin
			if (fail_count < REPORT_CAP)
				$error("result word 0x%0h with nothing expected", m_axis_tdata);
			fail_count++;
			return;
		end
		want = candidate_q.pop_front();
		if (got.out_char !== want.out_char)
			flag_field("out_char", 32'(want.out_char), 32'(got.out_char));
		if (got.char_position !== want.char_position)
			flag_field("char_position", 32'(want.char_position), 32'(got.char_position));
		if (got.last_char !== want.last_char)
			flag_field("last_char", 32'(want.last_char), 32'(got.last_char));
		if (got.out_of_range !== want.out_of_range)
			flag_field("out_of_range", 32'(want.out_of_range), 32'(got.out_of_range));
	endtask

	// result side: inputs sampled before the edge updates anything
	always @(posedge clk) begin
		if (arst_n === 1'b1 && m_axis_tvalid && m_axis_tready) check_char_word();
	end

	// result side back-pressure, counted here so the sender keeps running
	initial begin : result_sink
		int unsigned stall_left;
		bit hold_taken;
		stall_left = 0;
		hold_taken = 1'b0;
		m_axis_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (stall_left > 0) begin
				stall_left--;
			end else if (hold_outputs && !hold_taken) begin
				hold_taken = 1'b1;
				m_axis_tready <= 1'b0;
				stall_left = LONG_HOLD;
			end else if (sink_idles && $urandom_range(99) < 25) begin
				m_axis_tready <= 1'b0;
				stall_left = idle_len();
			end else begin
				m_axis_tready <= 1'b1;
			end
			@(posedge clk);
		end
	end

	// ends a hung run: no word moves on either side for too long
	always @(posedge clk) begin
		if (arst_n !== 1'b1 || (s_axis_tvalid && s_axis_tready)
				|| (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : stimulus
		hold_outputs = 1'b0;
		source_idles = 1'b1;
		sink_idles   = 1'b1;
		alphabet_cfg = ASIZE_RESET;
		length_cfg   = MLEN_RESET;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= 1'b0;
		cfg_wr_en     <= 1'b0;
		cfg_index     <= REG_ALPHABET_SIZE;
		cfg_wr_data   <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// every slot gets a byte first, so no generate reads an unwritten entry
		for (int s = 0; s < DEF_MAX_SYMBOLS; s++)
			send_word(OPC_LOAD, s[SLOT_W-1:0], SYM_W'($urandom_range(255)),
				{$urandom, $urandom}, 1'b0, '0);

		for (int i = 0; i < N_DIRECTED; i++)
			send_word(directed_rows[i].op, directed_rows[i].slot, directed_rows[i].value,
				directed_rows[i].key, directed_rows[i].typed, directed_rows[i].want);

		// random phases; phase 0 keeps the reset keyspace
		for (int p = 0; p < PHASES; p++) begin
			drain();
			case (p)
				1: set_keyspace(1, 16);     // unary alphabet, longest candidates
				2: set_keyspace(0, 0);      // both clamp up to one
				3: set_keyspace(2, 16);
				4: set_keyspace(128, 16);   // widest keyspace, groups past 64 bits
				5: set_keyspace(255, 31);   // both clamp down to the maximum
				6: set_keyspace(10, 1);
				7: set_keyspace(3, 5);
				default: if (p != 0) set_keyspace($urandom_range(128, 1), $urandom_range(16, 1));
			endcase
			// some phases run without idling on one side, and phase 2 on both
			source_idles = (p % 3) != 2;
			sink_idles   = (p % 4) != 2;
			for (int i = 0; i < PHASE_WORDS; i++) begin
				// the block fills up behind a long result hold-off
				if (p == 4 && i == 5) hold_outputs = 1'b1;
				// sender waits for every owed word before going on
				if (p == 3 && i == 20) drain();
				send_random_word();
			end
		end

		drain();
		if (fail_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// File: sim.f
rtl/core/ksic_pkg.sv
rtl/core/keyspace_index_to_candidate.sv
rtl/core/ksic_checker.sv
verif/tb_top.sv
